@@ src/selt_pkg.sv @@
// Shared types and constants for the record lock table.
package selt_pkg;

   localparam int TABLE_ENTRIES = 16;
   localparam int TXN_COUNT = 16;
   localparam int KEY_BITS = 32;
   localparam int IDX_W = $clog2(TABLE_ENTRIES);
   localparam int TXN_W = $clog2(TXN_COUNT);
   localparam int CNT_W = 5;

   localparam logic [1:0] CMD_LOCK_SH = 2'd0;
   localparam logic [1:0] CMD_LOCK_EX = 2'd1;
   localparam logic [1:0] CMD_UNLOCK = 2'd2;
   localparam logic [1:0] CMD_RELEASE = 2'd3;

   localparam logic [2:0] ST_OK = 3'd0;
   localparam logic [2:0] ST_EXCL_OTHER = 3'd1;
   localparam logic [2:0] ST_SHARED_OTHER = 3'd2;
   localparam logic [2:0] ST_NO_ENTRY = 3'd3;
   localparam logic [2:0] ST_NOT_HELD = 3'd4;
   localparam logic [2:0] ST_FULL = 3'd5;

   // controller to datapath
   typedef struct packed {
      logic load;   // capture request, clear search results
      logic scan;   // examine entry at index
      logic commit; // apply request to found/free entry
      logic rel;    // drop holds at index (release all)
      logic done;   // present result
   } ctl_type;

   // datapath to controller
   typedef struct packed {
      logic last;   // index at final entry
      logic is_rel; // command is release all
   } sts_type;

endpackage

@@ src/selt_ctrl.sv @@
// Sequencer that walks the table once per request.
module selt_ctrl (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  selt_pkg::sts_type sts,
   output selt_pkg::ctl_type ctl
);
   import selt_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_COMMIT = 2'd2;
   localparam logic [1:0] S_DONE = 2'd3;

   logic [1:0] state_ff, state_in;

   // advance state
   always_comb begin
      state_in = state_ff;
      ctl = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               ctl.load = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            ctl.scan = !sts.is_rel;
            ctl.rel = sts.is_rel;
            if (sts.last) state_in = sts.is_rel ? S_DONE : S_COMMIT;
         end
         S_COMMIT: begin
            ctl.commit = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            ctl.done = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   assign busy = (state_ff != S_IDLE);
endmodule

@@ src/selt_datapath.sv @@
// Lock table storage, entry scan and update logic.
module selt_datapath (
   input  logic clock,
   input  logic reset,
   input  logic [1:0] req_command,
   input  logic [3:0] req_txn_id,
   input  logic [31:0] req_record_key,
   input  selt_pkg::ctl_type ctl,
   output selt_pkg::sts_type sts,
   output logic rsp_valid,
   output logic [2:0] rsp_status,
   output logic [4:0] rsp_released_count
);
   import selt_pkg::*;

   logic [TABLE_ENTRIES-1:0] slot_valid_ff;
   logic [TABLE_ENTRIES-1:0] owner_valid_ff;
   logic [KEY_BITS-1:0] slot_key_ff [TABLE_ENTRIES];
   logic [TXN_W-1:0] owner_txn_ff [TABLE_ENTRIES];
   logic [TXN_COUNT-1:0] reader_mask_ff [TABLE_ENTRIES];

   logic [1:0] cmd_ff;
   logic [TXN_W-1:0] txn_ff;
   logic [KEY_BITS-1:0] key_ff;
   logic [IDX_W-1:0] idx_ff;
   logic hit_ff, free_ff;
   logic [IDX_W-1:0] hit_idx_ff, free_idx_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic rsp_valid_ff;
   logic [2:0] status_ff;
   logic [CNT_W-1:0] rcount_ff;

   logic [TXN_COUNT-1:0] bit_w;
   logic [TXN_COUNT-1:0] cur_mask, new_mask, hmask;
   logic cur_match, held, cur_own;
   logic [IDX_W-1:0] tgt;

   assign bit_w = TXN_COUNT'(1) << txn_ff;
   assign cur_mask = reader_mask_ff[idx_ff];
   assign cur_own = owner_valid_ff[idx_ff] && owner_txn_ff[idx_ff] == txn_ff;
   assign cur_match = slot_valid_ff[idx_ff] && slot_key_ff[idx_ff] == key_ff;
   assign held = slot_valid_ff[idx_ff] && (((cur_mask & bit_w) != '0) || cur_own);
   assign new_mask = cur_mask & ~bit_w;
   assign tgt = hit_ff ? hit_idx_ff : free_idx_ff;
   assign hmask = reader_mask_ff[hit_idx_ff];

   assign sts.last = (idx_ff == IDX_W'(TABLE_ENTRIES - 1));
   assign sts.is_rel = (cmd_ff == CMD_RELEASE);

   // hold request, walk index, record search results
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         cmd_ff <= req_command;
         txn_ff <= TXN_W'(req_txn_id % TXN_COUNT);
         key_ff <= KEY_BITS'(req_record_key);
         idx_ff <= '0;
         hit_ff <= 1'b0;
         free_ff <= 1'b0;
         hit_idx_ff <= '0;
         free_idx_ff <= '0;
         cnt_ff <= '0;
      end else if (ctl.scan || ctl.rel) begin
         idx_ff <= idx_ff + 1'b1;
         if (ctl.scan && cur_match && !hit_ff) begin
            hit_ff <= 1'b1;
            hit_idx_ff <= idx_ff;
         end
         if (ctl.scan && !slot_valid_ff[idx_ff] && !free_ff) begin
            free_ff <= 1'b1;
            free_idx_ff <= idx_ff;
         end
         if (ctl.rel && held && cnt_ff != 5'd31) cnt_ff <= cnt_ff + 1'b1;
      end
   end

   // update table
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= '0;
         owner_valid_ff <= '0;
         for (int i = 0; i < TABLE_ENTRIES; i++) reader_mask_ff[i] <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= ctl.done;
         if (ctl.rel && held) begin
            reader_mask_ff[idx_ff] <= new_mask;
            if (cur_own) owner_valid_ff[idx_ff] <= 1'b0;
            if (new_mask == '0 && (cur_own || !owner_valid_ff[idx_ff]))
               slot_valid_ff[idx_ff] <= 1'b0;
         end
         if (ctl.commit) begin
            status_ff <= ST_OK;
            rcount_ff <= '0;
            if (cmd_ff == CMD_UNLOCK) begin
               if (!hit_ff) status_ff <= ST_NO_ENTRY;
               else if ((hmask & bit_w) == '0 &&
                        !(owner_valid_ff[hit_idx_ff] && owner_txn_ff[hit_idx_ff] == txn_ff))
                  status_ff <= ST_NOT_HELD;
               else begin
                  reader_mask_ff[hit_idx_ff] <= hmask & ~bit_w;
                  if (owner_valid_ff[hit_idx_ff] && owner_txn_ff[hit_idx_ff] == txn_ff)
                     owner_valid_ff[hit_idx_ff] <= 1'b0;
                  if ((hmask & ~bit_w) == '0 && (!owner_valid_ff[hit_idx_ff] ||
                      owner_txn_ff[hit_idx_ff] == txn_ff))
                     slot_valid_ff[hit_idx_ff] <= 1'b0;
               end
            end else if (hit_ff && owner_valid_ff[hit_idx_ff] &&
                         owner_txn_ff[hit_idx_ff] != txn_ff) begin
               status_ff <= ST_EXCL_OTHER;
            end else if (hit_ff && cmd_ff == CMD_LOCK_EX && (hmask & ~bit_w) != '0) begin
               status_ff <= ST_SHARED_OTHER;
            end else if (!hit_ff && !free_ff) begin
               status_ff <= ST_FULL;
            end else begin
               slot_valid_ff[tgt] <= 1'b1;
               if (!hit_ff) slot_key_ff[tgt] <= key_ff;
               if (cmd_ff == CMD_LOCK_SH) begin
                  reader_mask_ff[tgt] <= (hit_ff ? hmask : '0) | bit_w;
                  if (!hit_ff) owner_valid_ff[tgt] <= 1'b0;
               end else begin
                  reader_mask_ff[tgt] <= '0;
                  owner_valid_ff[tgt] <= 1'b1;
                  owner_txn_ff[tgt] <= txn_ff;
               end
            end
         end else if (ctl.done && cmd_ff == CMD_RELEASE) begin
            status_ff <= ST_OK;
            rcount_ff <= cnt_ff;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = status_ff;
   assign rsp_released_count = rcount_ff;
endmodule

@@ src/shared_exclusive_lock_table.sv @@
// Top level of the shared/exclusive record lock table.
// The controller walks the table one entry per cycle, then commits the request and
// presents the result; release all drops holds during the walk and skips the commit step.
// A new request is taken only once the previous one is through; busy is high
// meanwhile.
// Reset clears all valid bits and reader masks at once; no clearing pass.
// The result is shown one cycle on rsp_valid; the receiver cannot stall.
module shared_exclusive_lock_table (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  logic [1:0] req_command,
   input  logic [3:0] req_txn_id,
   input  logic [31:0] req_record_key,
   output logic rsp_valid,
   output logic [2:0] rsp_status,
   output logic [4:0] rsp_released_count
);
   import selt_pkg::*;

   ctl_type ctl;
   sts_type sts;

   selt_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .sts(sts), .ctl(ctl)
   );

   selt_datapath u_dp (
      .clock(clock), .reset(reset), .req_command(req_command), .req_txn_id(req_txn_id),
      .req_record_key(req_record_key), .ctl(ctl), .sts(sts), .rsp_valid(rsp_valid),
      .rsp_status(rsp_status), .rsp_released_count(rsp_released_count)
   );
endmodule

@@ src/selt_checker.sv @@
// Port-level checks for the lock table, bound to the top level.
module selt_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid,
   input logic [2:0] rsp_status,
   input logic [4:0] rsp_released_count
);
   import selt_pkg::*;

   // accepted word makes block busy
   a_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("not busy after accept");
   // result ends the busy period
   a_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("busy with result");
   // status in range
   a_stat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= ST_FULL) else $error("bad status");
   // count only with ok status
   a_cnt: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_released_count != 5'd0 |-> rsp_status == ST_OK)
      else $error("count with error");
   // result is single cycle
   a_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("double result");
endmodule

bind shared_exclusive_lock_table selt_checker u_chk (
   .clock(clock), .reset(reset), .start(start), .busy(busy), .rsp_valid(rsp_valid),
   .rsp_status(rsp_status), .rsp_released_count(rsp_released_count)
);

@@ tb/tb.sv @@
// Self-checking testbench for the shared/exclusive record lock table.
`timescale 1ns / 1ps

module tb;
   import selt_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int N_RANDOM = 630;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   logic [1:0] req_command;
   logic [3:0] req_txn_id;
   logic [31:0] req_record_key;
   logic rsp_valid;
   logic [2:0] rsp_status;
   logic [4:0] rsp_released_count;

   shared_exclusive_lock_table i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_command(req_command), .req_txn_id(req_txn_id),
      .req_record_key(req_record_key), .rsp_valid(rsp_valid),
      .rsp_status(rsp_status), .rsp_released_count(rsp_released_count)
   );

   typedef struct {
      logic [2:0] status;
      logic [4:0] released;
   } lock_word_type;

   // directed row: command, txn, key, typed-in expectation (check = 1)
   typedef struct {
      logic [1:0] cmd;
      logic [3:0] txn;
      logic [31:0] key;
      bit check;
      logic [2:0] status;
      logic [4:0] released;
   } lock_row_type;

   // shadow lock table
   bit slot_used[TABLE_ENTRIES];
   logic [31:0] slot_rec[TABLE_ENTRIES];
   bit excl_held[TABLE_ENTRIES];
   logic [3:0] excl_txn[TABLE_ENTRIES];
   logic [15:0] share_bits[TABLE_ENTRIES];

   lock_word_type pending_words[$];
   int errors = 0;
   int cycles = 0;
   bit quiet = 0;
   logic [31:0] key_pool[8];

   function automatic int lookup_slot(logic [31:0] key);
      for (int i = 0; i < TABLE_ENTRIES; i++)
         if (slot_used[i] && slot_rec[i] == key) return i;
      return -1;
   endfunction

   function automatic bit drop_txn(int s, logic [3:0] txn);
      bit held;
      held = 0;
      if (share_bits[s][txn]) begin
         share_bits[s][txn] = 1'b0;
         held = 1;
      end
      if (excl_held[s] && excl_txn[s] == txn) begin
         excl_held[s] = 0;
         held = 1;
      end
      if (share_bits[s] == 0 && !excl_held[s]) slot_used[s] = 0;
      return held;
   endfunction

   // compute the lock table's answer and update the shadow state
   function automatic lock_word_type lock_answer(logic [1:0] cmd, logic [3:0] txn,
                                                 logic [31:0] key);
      lock_word_type w;
      int s;
      w.status = ST_OK;
      w.released = 0;
      if (cmd == CMD_LOCK_SH || cmd == CMD_LOCK_EX) begin
         s = lookup_slot(key);
         if (s >= 0 && excl_held[s] && excl_txn[s] != txn) begin
            w.status = ST_EXCL_OTHER;
         end else if (s >= 0 && cmd == CMD_LOCK_EX
                      && (share_bits[s] & ~(16'd1 << txn)) != 0) begin
            w.status = ST_SHARED_OTHER;
         end else begin
            if (s < 0) begin
               for (int i = 0; i < TABLE_ENTRIES; i++)
                  if (s < 0 && !slot_used[i]) s = i;
               if (s >= 0) begin
                  slot_used[s] = 1;
                  slot_rec[s] = key;
                  excl_held[s] = 0;
                  share_bits[s] = 0;
               end
            end
            if (s < 0) w.status = ST_FULL;
            else if (cmd == CMD_LOCK_SH) share_bits[s][txn] = 1'b1;
            else begin
               share_bits[s] = 0;
               excl_held[s] = 1;
               excl_txn[s] = txn;
            end
         end
      end else if (cmd == CMD_UNLOCK) begin
         s = lookup_slot(key);
         if (s < 0) w.status = ST_NO_ENTRY;
         else if (!drop_txn(s, txn)) w.status = ST_NOT_HELD;
      end else begin
         for (int i = 0; i < TABLE_ENTRIES; i++)
            if (slot_used[i] && drop_txn(i, txn))
               if (w.released < 31) w.released++;
      end
      return w;
   endfunction

   // drive one word and wait for its acceptance
   task automatic send_word(logic [1:0] cmd, logic [3:0] txn, logic [31:0] key,
                            bit check, logic [2:0] st, logic [4:0] rc);
      lock_word_type w;
      int gap;
      @(negedge clock);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 19);
         repeat (gap) @(negedge clock);
      end
      start <= 1'b1;
      req_command <= cmd;
      req_txn_id <= txn;
      req_record_key <= key;
      do @(posedge clock); while (busy);
      w = lock_answer(cmd, txn, key);
      if (check && (w.status != st || w.released != rc)) begin
         $error("table row mismatch: status %0d/%0d released %0d/%0d",
                st, w.status, rc, w.released);
         errors++;
      end
      pending_words.insert(pending_words.size(), w);
      @(negedge clock);
      start <= 1'b0;
   endtask

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // compare each result word with the oldest expectation
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && rsp_valid) begin
         if (pending_words.size() == 0) begin
            $error("unexpected result word");
            errors++;
         end else begin
            lock_word_type w;
            w = pending_words.pop_front();
            if (rsp_status !== w.status) begin
               $error("status expected %0d actual %0d", w.status, rsp_status);
               errors++;
            end
            if (rsp_released_count !== w.released) begin
               $error("released_count expected %0d actual %0d",
                      w.released, rsp_released_count);
               errors++;
            end
         end
      end
      if (cycles > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      lock_row_type rows[$];
      logic [1:0] c;
      logic [3:0] t;
      logic [31:0] k;
      int r;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         slot_used[i] = 0;
         excl_held[i] = 0;
         share_bits[i] = 0;
      end
      reset = 1;
      start = 0;
      req_command = CMD_LOCK_SH;
      req_txn_id = 0;
      req_record_key = 0;

      // directed: empty-table cases, extremes, refusals, full table
      rows.insert(rows.size(),
                  lock_row_type'{CMD_UNLOCK, 4'd0, 32'd0, 1, ST_NO_ENTRY, 5'd0});
      rows.insert(rows.size(),
                  lock_row_type'{CMD_RELEASE, 4'd15, 32'hFFFF_FFFF, 1, ST_OK, 5'd0});
      rows.insert(rows.size(),
                  lock_row_type'{CMD_LOCK_SH, 4'd0, 32'hFFFF_FFFF, 1, ST_OK, 5'd0});
      rows.insert(rows.size(),
                  lock_row_type'{CMD_LOCK_EX, 4'd15, 32'hFFFF_FFFF, 1,
                                 ST_SHARED_OTHER, 5'd0});
      rows.insert(rows.size(),
                  lock_row_type'{CMD_LOCK_EX, 4'd0, 32'hFFFF_FFFF, 1, ST_OK, 5'd0});
      rows.insert(rows.size(),
                  lock_row_type'{CMD_LOCK_SH, 4'd15, 32'hFFFF_FFFF, 1,
                                 ST_EXCL_OTHER, 5'd0});
      rows.insert(rows.size(),
                  lock_row_type'{CMD_LOCK_SH, 4'd0, 32'hFFFF_FFFF, 1, ST_OK, 5'd0});
      rows.insert(rows.size(),
                  lock_row_type'{CMD_LOCK_EX, 4'd0, 32'hFFFF_FFFF, 1, ST_OK, 5'd0});
      rows.insert(rows.size(),
                  lock_row_type'{CMD_UNLOCK, 4'd15, 32'hFFFF_FFFF, 1, ST_NOT_HELD, 5'd0});
      rows.insert(rows.size(),
                  lock_row_type'{CMD_LOCK_SH, 4'd15, 32'd0, 1, ST_OK, 5'd0});
      rows.insert(rows.size(),
                  lock_row_type'{CMD_UNLOCK, 4'd0, 32'hFFFF_FFFF, 1, ST_OK, 5'd0});
      for (int i = 0; i < TABLE_ENTRIES; i++)
         rows.insert(rows.size(),
                     lock_row_type'{CMD_LOCK_SH, 4'd5, 32'h100 + i, 0, ST_OK, 5'd0});
      rows.insert(rows.size(),
                  lock_row_type'{CMD_LOCK_EX, 4'd6, 32'h5555_AAAA, 1, ST_FULL, 5'd0});
      rows.insert(rows.size(),
                  lock_row_type'{CMD_RELEASE, 4'd5, 32'd0, 1, ST_OK, 5'd15});

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 0;

      foreach (rows[i])
         send_word(rows[i].cmd, rows[i].txn, rows[i].key, rows[i].check,
                   rows[i].status, rows[i].released);

      // hold off until the table has answered everything
      wait (pending_words.size() == 0);
      @(negedge clock);

      // random: small key pool for contention, rare wide keys and releases
      for (int n = 0; n < N_RANDOM; n++) begin
         if (n % 80 == 0)
            foreach (key_pool[j]) key_pool[j] = $urandom();
         if (n == N_RANDOM - 60) quiet = 1;
         r = $urandom_range(0, 99);
         c = (r < 40) ? CMD_LOCK_SH : (r < 65) ? CMD_LOCK_EX :
             (r < 93) ? CMD_UNLOCK : CMD_RELEASE;
         t = $urandom_range(0, 15);
         k = ($urandom_range(0, 9) == 0) ? $urandom()
                                         : key_pool[$urandom_range(0, 7)];
         send_word(c, t, k, 0, ST_OK, 5'd0);
      end

      wait (pending_words.size() == 0);
      repeat (25) @(posedge clock);
      if (errors == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end
endmodule
